// ----- hw/rtl/dtc_pkg.sv -----
// Package for the disciplined timeline clock: opcodes, sequencer states,
// arithmetic constants and the status struct of the serial units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned PPB_W   = 31;
  localparam int unsigned FSTEP_W = 21;
  localparam int unsigned OP_W    = 3;

  // Serial product: magnitude times a factor below 2^31
  localparam int unsigned PROD_W    = TIME_W + PPB_W;
  localparam int unsigned MUL_STEPS = TIME_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // One billion, and the clamp on the accumulated frequency error
  localparam logic [PPB_W-1:0]        BILLION   = 31'd1_000_000_000;
  localparam logic signed [PPB_W:0]   PPB_LIMIT = 32'sd999_999_999;

  // Opcodes
  typedef logic [OP_W-1:0] opcode_t;
  localparam opcode_t OP_LOC_POINT = 3'd0;
  localparam opcode_t OP_LOC_IVAL  = 3'd1;
  localparam opcode_t OP_REM_POINT = 3'd2;
  localparam opcode_t OP_REM_IVAL  = 3'd3;
  localparam opcode_t OP_ADJ_FREQ  = 3'd4;
  localparam opcode_t OP_ADJ_OFFS  = 3'd5;
  localparam opcode_t OP_SET_TIME  = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_FIX,
    S_FINAL,
    S_OUT
  } state_t;

  // Status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtc_if.sv -----
// Request and result channel interfaces of the disciplined timeline clock.
// Depends on dtc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtc_req_if;
  logic                               valid;
  logic                               ready;
  logic [dtc_pkg::OP_W-1:0]           opcode;
  logic [dtc_pkg::TIME_W-1:0]         core_time;
  logic signed [dtc_pkg::TIME_W-1:0]  operand_time;
  logic signed [dtc_pkg::FSTEP_W-1:0] freq_adjust_ppb;

  modport source (
    output valid, opcode, core_time, operand_time, freq_adjust_ppb,
    input  ready
  );
  modport sink (
    input  valid, opcode, core_time, operand_time, freq_adjust_ppb,
    output ready
  );
endinterface

interface dtc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dtc_pkg::TIME_W-1:0] result_time;

  modport source (output valid, result_time, input ready);
  modport sink (input valid, result_time, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dtc_serial_mul.sv -----
// Bit-serial multiplier: 64-bit magnitude times a 31-bit factor, one
// multiplicand bit per cycle with a 32-bit adder. Depends on dtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtc_serial_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [dtc_pkg::TIME_W-1:0]   multiplicand,
  input  wire logic [dtc_pkg::PPB_W-1:0]    multiplier,
  output dtc_pkg::unit_stat_t               stat,
  output logic [dtc_pkg::PROD_W-1:0]        product
);

  logic                           busy;
  logic                           done;
  logic [dtc_pkg::MUL_CNT_W-1:0]  cnt;
  logic [dtc_pkg::PPB_W-1:0]      factor;
  logic [dtc_pkg::PPB_W-1:0]      hi;
  logic [dtc_pkg::TIME_W-1:0]     lo;
  logic [dtc_pkg::PPB_W:0]        sum;
  logic                           last_step;

  // Add the factor into the upper half when the low bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, factor} : '0);
  assign last_step = (cnt == dtc_pkg::MUL_CNT_W'(dtc_pkg::MUL_STEPS - 1));

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right by one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      factor <= multiplier;
      hi     <= '0;
      lo     <= multiplicand;
    end else if (busy) begin
      hi <= sum[dtc_pkg::PPB_W:1];
      lo <= {sum[0], lo[dtc_pkg::TIME_W-1:1]};
    end
  end

  assign product   = {hi, lo};
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- hw/rtl/dtc_serial_div.sv -----
// Restoring bit-serial divider: 95-bit dividend by a 31-bit divisor, one
// quotient bit per cycle, low 64 quotient bits kept. Depends on dtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtc_serial_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [dtc_pkg::PROD_W-1:0]   dividend,
  input  wire logic [dtc_pkg::PPB_W-1:0]    divisor,
  output dtc_pkg::unit_stat_t               stat,
  output logic [dtc_pkg::TIME_W-1:0]        quotient
);

  logic                           busy;
  logic                           done;
  logic [dtc_pkg::DIV_CNT_W-1:0]  cnt;
  logic [dtc_pkg::PPB_W-1:0]      dvs;
  logic [dtc_pkg::PROD_W-1:0]     num;
  logic [dtc_pkg::PPB_W-1:0]      rem;
  logic [dtc_pkg::TIME_W-1:0]     quo;
  logic [dtc_pkg::PPB_W:0]        trial;
  logic [dtc_pkg::PPB_W:0]        diff;
  logic                           fits;
  logic                           last_step;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem, num[dtc_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});
  assign last_step = (cnt == dtc_pkg::DIV_CNT_W'(dtc_pkg::DIV_STEPS - 1));

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      num <= dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[dtc_pkg::PROD_W-2:0], 1'b0};
      rem <= fits ? diff[dtc_pkg::PPB_W-1:0] : trial[dtc_pkg::PPB_W-1:0];
      quo <= {quo[dtc_pkg::TIME_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- hw/rtl/disciplined_timeline_clock.sv -----
// Disciplined timeline clock: projects times between local core time and a
// ppb-corrected timeline, and applies frequency, offset and time steps.
// Depends on dtc_pkg, dtc_if, dtc_serial_mul and dtc_serial_div.
//
// Usage:
//   req carries one request (opcode, core_time, operand_time,
//   freq_adjust_ppb); rsp returns one result_time for every request.
//   Both channels move a request when valid and ready are high together.
//   One request is worked on at a time; req.ready is high only while the
//   sequencer is idle.
//   Projections and frequency/offset adjustments run a 64-step serial
//   multiply and a 95-step serial divide, then pass S_FIX and S_FINAL;
//   S_OUT loads the result into the output register, and the next request
//   is taken after that. Set time and the unused opcode skip both units.
//   The result sits in an output register, so the last result may wait on
//   rsp while the next request is already being worked on; a finished
//   result waits in the sequencer until the output register frees up.
//   Reset clears the timeline offset, the discipline time and the
//   frequency error to zero and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module disciplined_timeline_clock (
  input wire logic  clk,
  input wire logic  rst,
  dtc_req_if.sink   req,
  dtc_rsp_if.source rsp
);

  localparam int unsigned TW = dtc_pkg::TIME_W;
  localparam int unsigned PW = dtc_pkg::PPB_W;

  dtc_pkg::state_t  state;
  dtc_pkg::state_t  state_next;

  // Request fields
  dtc_pkg::opcode_t            op;
  logic [TW-1:0]               now;
  logic [TW-1:0]               t;
  logic [dtc_pkg::FSTEP_W-1:0] fstep;

  // Timeline state
  logic [TW-1:0]  offset;
  logic [TW-1:0]  last;
  logic [PW-1:0]  ppb;

  // Work registers
  logic [TW-1:0]  x;
  logic [TW-1:0]  x_next;
  logic [TW-1:0]  acc;
  logic [TW-1:0]  base;
  logic [TW-1:0]  addend;
  logic [TW-1:0]  mval;
  logic [TW-1:0]  res;
  logic [TW-1:0]  res_next;
  logic           neg;
  logic           unscale;
  logic           uses_unit;

  // Output register
  logic           out_valid;
  logic [TW-1:0]  out_time;

  // Serial units
  logic                       mul_start;
  logic                       div_start;
  dtc_pkg::unit_stat_t        mul_stat;
  dtc_pkg::unit_stat_t        div_stat;
  logic [TW-1:0]              mag;
  logic [PW-1:0]              ppb_mag;
  logic [PW-1:0]              factor;
  logic [PW-1:0]              divisor;
  logic [dtc_pkg::PROD_W-1:0] product;
  logic [TW-1:0]              quotient;

  // Frequency update
  logic signed [PW:0]  ppb_sum;
  logic signed [PW:0]  ppb_sat;

  logic accept;
  logic out_free;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Decode the operation class
  always_comb begin
    unscale   = 1'b0;
    uses_unit = 1'b1;
    case (op) inside
      dtc_pkg::OP_REM_POINT, dtc_pkg::OP_REM_IVAL: unscale = 1'b1;
      dtc_pkg::OP_LOC_POINT, dtc_pkg::OP_LOC_IVAL,
      dtc_pkg::OP_ADJ_FREQ, dtc_pkg::OP_ADJ_OFFS: unscale = 1'b0;
      default: uses_unit = 1'b0;
    endcase
  end

  // Pick the value to scale
  always_comb begin
    case (op) inside
      dtc_pkg::OP_LOC_POINT:                       x_next = t - last;
      dtc_pkg::OP_REM_POINT:                       x_next = t - offset;
      dtc_pkg::OP_ADJ_FREQ, dtc_pkg::OP_ADJ_OFFS:  x_next = now - last;
      default:                                     x_next = t;
    endcase
  end

  // Pick what the scaled term is added to
  always_comb begin
    case (op) inside
      dtc_pkg::OP_LOC_POINT, dtc_pkg::OP_ADJ_FREQ, dtc_pkg::OP_ADJ_OFFS: begin
        base   = offset;
        addend = x;
      end
      dtc_pkg::OP_LOC_IVAL: begin
        base   = '0;
        addend = x;
      end
      dtc_pkg::OP_REM_POINT: begin
        base   = last;
        addend = '0;
      end
      default: begin
        base   = '0;
        addend = '0;
      end
    endcase
  end

  // Set up the scaling: x*ppb/1e9 or x*1e9/(1e9+ppb), on magnitudes
  assign mag     = x[TW-1] ? (TW'(0) - x) : x;
  assign ppb_mag = ppb[PW-1] ? (PW'(0) - ppb) : ppb;
  assign factor  = unscale ? dtc_pkg::BILLION : ppb_mag;
  assign divisor = unscale ? (dtc_pkg::BILLION + ppb) : dtc_pkg::BILLION;

  // Accumulate and clamp the frequency error
  always_comb begin
    ppb_sum = $signed({ppb[PW-1], ppb})
            + $signed({{(PW + 1 - dtc_pkg::FSTEP_W){fstep[dtc_pkg::FSTEP_W-1]}}, fstep});
    if (ppb_sum > dtc_pkg::PPB_LIMIT) begin
      ppb_sat = dtc_pkg::PPB_LIMIT;
    end else if (ppb_sum < -dtc_pkg::PPB_LIMIT) begin
      ppb_sat = -dtc_pkg::PPB_LIMIT;
    end else begin
      ppb_sat = ppb_sum;
    end
  end

  // Form the result
  always_comb begin
    case (op) inside
      dtc_pkg::OP_SET_TIME: res_next = t;
      dtc_pkg::OP_LOC_POINT, dtc_pkg::OP_LOC_IVAL, dtc_pkg::OP_REM_POINT,
      dtc_pkg::OP_REM_IVAL, dtc_pkg::OP_ADJ_FREQ, dtc_pkg::OP_ADJ_OFFS:
        res_next = acc + mval;
      default: res_next = '0;
    endcase
  end

  dtc_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mag),
    .multiplier   (factor),
    .stat         (mul_stat),
    .product      (product)
  );

  dtc_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      dtc_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = dtc_pkg::S_PREP;
        end
      end
      dtc_pkg::S_PREP: begin
        state_next = uses_unit ? dtc_pkg::S_LOAD : dtc_pkg::S_FINAL;
      end
      dtc_pkg::S_LOAD: begin
        mul_start  = 1'b1;
        state_next = dtc_pkg::S_MUL;
      end
      dtc_pkg::S_MUL: begin
        if (mul_stat.done) begin
          div_start  = 1'b1;
          state_next = dtc_pkg::S_DIV;
        end
      end
      dtc_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_next = dtc_pkg::S_FIX;
        end
      end
      dtc_pkg::S_FIX: begin
        state_next = dtc_pkg::S_FINAL;
      end
      dtc_pkg::S_FINAL: begin
        state_next = dtc_pkg::S_OUT;
      end
      dtc_pkg::S_OUT: begin
        if (out_free) begin
          state_next = dtc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dtc_pkg::S_IDLE;
      end
    endcase
  end

  // Capture the request and run the datapath steps
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.opcode;
      now   <= req.core_time;
      t     <= req.operand_time;
      fstep <= req.freq_adjust_ppb;
    end
    case (state)
      dtc_pkg::S_PREP: begin
        x <= x_next;
      end
      dtc_pkg::S_LOAD: begin
        acc <= base + addend;
        neg <= unscale ? x[TW-1] : (x[TW-1] ^ ppb[PW-1]);
      end
      dtc_pkg::S_FIX: begin
        mval <= neg ? (TW'(0) - quotient) : quotient;
        acc  <= acc + ((op == dtc_pkg::OP_ADJ_OFFS) ? t : TW'(0));
      end
      dtc_pkg::S_FINAL: begin
        res <= res_next;
      end
      default: begin
      end
    endcase
  end

  // Update the timeline on adjust and set operations
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      last   <= '0;
      ppb    <= '0;
    end else if (state == dtc_pkg::S_FINAL) begin
      case (op) inside
        dtc_pkg::OP_ADJ_FREQ: begin
          offset <= res_next;
          last   <= now;
          ppb    <= ppb_sat[PW-1:0];
        end
        dtc_pkg::OP_ADJ_OFFS, dtc_pkg::OP_SET_TIME: begin
          offset <= res_next;
          last   <= now;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dtc_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtc_pkg::S_OUT && out_free) begin
      out_time <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_time = out_time;

  // No request is taken while a serial unit is working
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (mul_stat.busy || div_stat.busy) |-> !req.ready)
    else $error("request taken while serial unit busy");

  // The two serial units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // The frequency error stays inside its clamp
  a_ppb_clamped: assert property (@(posedge clk) disable iff (rst)
    ($signed(ppb) <= $signed(dtc_pkg::PPB_LIMIT[PW-1:0]))
    && ($signed(ppb) >= -$signed(dtc_pkg::PPB_LIMIT[PW-1:0])))
    else $error("frequency error out of range");

  // A taken request starts the sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == dtc_pkg::S_PREP))
    else $error("sequencer did not start after request");

  // The divider starts right after the multiplier finishes
  a_div_follows_mul: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |=> div_stat.busy)
    else $error("divider did not start after multiplier");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for the disciplined timeline clock: sends requests on
// the request channel, predicts every result_time and checks the result channel.
// Depends on dtc_pkg, dtc_if and the disciplined_timeline_clock RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TIME_W  = dtc_pkg::TIME_W;
  localparam int unsigned PPB_W   = dtc_pkg::PPB_W;
  localparam int unsigned FSTEP_W = dtc_pkg::FSTEP_W;
  localparam logic [PPB_W-1:0]      BILLION   = dtc_pkg::BILLION;
  localparam logic signed [PPB_W:0] PPB_LIMIT = dtc_pkg::PPB_LIMIT;

  typedef dtc_pkg::opcode_t opcode_t;

  localparam opcode_t OP_UNUSED = 3'd7;
  localparam logic [TIME_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [TIME_W-1:0] T_ONES = '1;
  localparam logic [FSTEP_W-1:0] STEP_MAX = 21'h0F_FFFF;
  localparam logic [FSTEP_W-1:0] STEP_MIN = 21'h10_0000;

  typedef struct {
    opcode_t                    opcode;
    logic [TIME_W-1:0]          core_time;
    logic [TIME_W-1:0]          operand_time;
    logic signed [FSTEP_W-1:0]  freq_adjust_ppb;
  } clk_req_t;

  logic clk = 1'b0;
  logic rst;

  dtc_req_if req_ch ();
  dtc_rsp_if rsp_ch ();

  disciplined_timeline_clock dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // Predicted timeline state
  logic [TIME_W-1:0]       tl_offset;
  logic [TIME_W-1:0]       tl_anchor;
  logic signed [PPB_W-1:0] tl_ppb;

  logic [TIME_W-1:0] expected_times[$];
  logic [TIME_W-1:0] core_now;
  int unsigned       err_count;
  int unsigned       req_count;
  int unsigned       result_count;
  int                rsp_hold;
  bit                req_gaps_on;
  bit                rsp_gaps_on;

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic int draw_gap(input bit on);
    return on ? int'($urandom_range(0, 13)) : 0;
  endfunction

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // trunc(span * ppb / 1e9) with span read as two's complement, wrapped to 64 bits
  function automatic logic [TIME_W-1:0] ppb_correction(input logic [TIME_W-1:0] span);
    logic              span_neg;
    logic              ppb_neg;
    logic [TIME_W-1:0] mag;
    longint            ppb_val;
    logic [127:0]      scaled;
    span_neg = span[TIME_W-1];
    mag = span_neg ? -span : span;
    ppb_val = longint'(tl_ppb);
    ppb_neg = ppb_val < 0;
    scaled = {64'd0, mag} * 128'(ppb_neg ? -ppb_val : ppb_val) / 128'(BILLION);
    return (span_neg != ppb_neg) ? -scaled[TIME_W-1:0] : scaled[TIME_W-1:0];
  endfunction

  // trunc(span * 1e9 / (1e9 + ppb)), wrapped to 64 bits
  function automatic logic [TIME_W-1:0] rescale_to_local(input logic [TIME_W-1:0] span);
    logic              span_neg;
    logic [TIME_W-1:0] mag;
    logic [127:0]      divisor;
    logic [127:0]      scaled;
    span_neg = span[TIME_W-1];
    mag = span_neg ? -span : span;
    divisor = 128'(longint'(BILLION) + longint'(tl_ppb));
    scaled = {64'd0, mag} * 128'(BILLION) / divisor;
    return span_neg ? -scaled[TIME_W-1:0] : scaled[TIME_W-1:0];
  endfunction

  // Fold the corrected elapsed time into the offset and re-anchor at now
  function automatic void fold_elapsed(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] span;
    span = now - tl_anchor;
    tl_offset = tl_offset + span + ppb_correction(span);
    tl_anchor = now;
  endfunction

  // Apply one request to the predicted state and return its result_time
  function automatic logic [TIME_W-1:0] timeline_step(input clk_req_t r);
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] res;
    longint            ppb_sum;
    res = '0;
    case (r.opcode)
      dtc_pkg::OP_LOC_POINT: begin
        span = r.operand_time - tl_anchor;
        res = tl_offset + span + ppb_correction(span);
      end
      dtc_pkg::OP_LOC_IVAL: res = r.operand_time + ppb_correction(r.operand_time);
      dtc_pkg::OP_REM_POINT:
        res = tl_anchor + rescale_to_local(r.operand_time - tl_offset);
      dtc_pkg::OP_REM_IVAL: res = rescale_to_local(r.operand_time);
      dtc_pkg::OP_ADJ_FREQ: begin
        fold_elapsed(r.core_time);
        ppb_sum = longint'(tl_ppb) + longint'(r.freq_adjust_ppb);
        if (ppb_sum > longint'(PPB_LIMIT)) ppb_sum = longint'(PPB_LIMIT);
        if (ppb_sum < -longint'(PPB_LIMIT)) ppb_sum = -longint'(PPB_LIMIT);
        tl_ppb = PPB_W'(ppb_sum);
        res = tl_offset;
      end
      dtc_pkg::OP_ADJ_OFFS: begin
        fold_elapsed(r.core_time);
        tl_offset = tl_offset + r.operand_time;
        res = tl_offset;
      end
      dtc_pkg::OP_SET_TIME: begin
        tl_anchor = r.core_time;
        tl_offset = r.operand_time;
        res = tl_offset;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Send one request, then record its predicted result once it is taken
  task automatic issue_request(input opcode_t op, input logic [TIME_W-1:0] core,
                               input logic [TIME_W-1:0] operand,
                               input logic [FSTEP_W-1:0] step);
    clk_req_t r;
    int       gap;
    r.opcode = op;
    r.core_time = core;
    r.operand_time = operand;
    r.freq_adjust_ppb = step;
    if (req_count % 50 == 0) req_gaps_on = ($urandom_range(0, 3) != 0);
    req_count++;
    gap = draw_gap(req_gaps_on);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.core_time <= core;
    req_ch.operand_time <= operand;
    req_ch.freq_adjust_ppb <= step;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_times.push_back(timeline_step(r));
  endtask

  // Move core time forward mostly, sometimes jump or step back
  function automatic void advance_core();
    case ($urandom_range(0, 19))
      0: core_now = rand64();
      1: core_now = core_now - $urandom_range(0, 1 << 20);
      default: core_now = core_now + (rand64() >> $urandom_range(20, 63));
    endcase
  endfunction

  // Operand: raw bits, extremes, or a value near the current point of interest
  function automatic logic [TIME_W-1:0] pick_operand(input opcode_t op);
    logic [TIME_W-1:0] jitter;
    jitter = $signed(rand64()) >>> $urandom_range(8, 62);
    case ($urandom_range(0, 9))
      0, 1: return rand64();
      2: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 64'd1;
          2: return T_ONES;
          3: return T_MAX;
          default: return T_MIN;
        endcase
      end
      default: begin
        case (op)
          dtc_pkg::OP_LOC_POINT: return core_now + jitter;
          dtc_pkg::OP_REM_POINT: return tl_offset + jitter;
          default: return jitter;
        endcase
      end
    endcase
  endfunction

  function automatic logic [FSTEP_W-1:0] rand_step();
    case ($urandom_range(0, 9))
      0, 1: return FSTEP_W'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return STEP_MAX;
          1: return STEP_MIN;
          2: return 21'sd1000000;
          3: return -21'sd1000000;
          default: return '0;
        endcase
      end
      default: return FSTEP_W'($urandom_range(0, 2000000) - 1000000);
    endcase
  endfunction

  // Field extremes, every opcode, wrap and truncation corners
  task automatic test_directed_cases();
    issue_request(dtc_pkg::OP_LOC_POINT, '0, '0, '0);
    issue_request(dtc_pkg::OP_LOC_IVAL, '0, T_MAX, '0);
    issue_request(dtc_pkg::OP_REM_IVAL, '0, T_MIN, '0);
    // field-extreme steps are taken as they are
    issue_request(dtc_pkg::OP_ADJ_FREQ, 64'd1000, '0, STEP_MAX);
    // core time behind the anchor gives a negative elapsed time
    issue_request(dtc_pkg::OP_ADJ_FREQ, 64'd500, '0, STEP_MIN);
    issue_request(dtc_pkg::OP_ADJ_FREQ, 64'd2000, '0, '0);
    // negative ppb: truncate toward zero on both signs
    issue_request(dtc_pkg::OP_LOC_IVAL, '0, -64'sd1999999999, '0);
    issue_request(dtc_pkg::OP_LOC_IVAL, '0, 64'd1999999999, '0);
    issue_request(dtc_pkg::OP_REM_IVAL, '0, -64'sd7, '0);
    issue_request(dtc_pkg::OP_ADJ_FREQ, 64'd3000, T_ONES, 21'sd123456);
    issue_request(dtc_pkg::OP_LOC_POINT, T_ONES, T_ONES, '0);
    issue_request(dtc_pkg::OP_REM_POINT, '0, T_MIN, '0);
    issue_request(dtc_pkg::OP_REM_POINT, T_ONES, T_MAX, STEP_MAX);
    // offset sums wrap modulo 2^64
    issue_request(dtc_pkg::OP_ADJ_OFFS, T_ONES, T_MAX, '0);
    issue_request(dtc_pkg::OP_ADJ_OFFS, 64'd5, T_MIN, '0);
    issue_request(dtc_pkg::OP_SET_TIME, T_ONES, T_MIN, STEP_MIN);
    issue_request(dtc_pkg::OP_LOC_POINT, '0, '0, '0);
    issue_request(dtc_pkg::OP_SET_TIME, '0, '0, '0);
    // unused opcode leaves state alone and returns zero
    issue_request(OP_UNUSED, T_ONES, T_ONES, '1);
    issue_request(OP_UNUSED, '0, '0, '0);
    issue_request(dtc_pkg::OP_ADJ_FREQ, 64'd1_000_000_000, T_MAX, -21'sd1000000);
    issue_request(dtc_pkg::OP_REM_IVAL, '0, 64'd1, '0);
    issue_request(dtc_pkg::OP_LOC_POINT, '0, 64'd1_500_000_000, '0);
    core_now = 64'd1_000_000_000;
  endtask

  // Clock traffic with mostly forward core time and mixed operations
  task automatic test_random_traffic();
    opcode_t op;
    repeat (750) begin
      advance_core();
      op = ($urandom_range(0, 99) < 4) ? OP_UNUSED : opcode_t'($urandom_range(0, 6));
      issue_request(op, core_now, pick_operand(op), rand_step());
    end
  endtask

  // Ramp the frequency error into one clamp, projecting along the way
  task automatic test_freq_clamp();
    int                  dir;
    int                  pinned;
    longint              target;
    opcode_t             op;
    logic [FSTEP_W-1:0]  step;
    dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
    target = dir * longint'(PPB_LIMIT);
    pinned = 0;
    while (pinned < 6) begin
      advance_core();
      if ($urandom_range(0, 7) == 0) begin
        op = opcode_t'($urandom_range(0, 3));
        issue_request(op, core_now, pick_operand(op), rand_step());
      end else begin
        step = (dir > 0) ? FSTEP_W'($urandom_range(900000, 1048575))
                         : -FSTEP_W'($urandom_range(900000, 1048576));
        issue_request(dtc_pkg::OP_ADJ_FREQ, core_now,
                      pick_operand(dtc_pkg::OP_ADJ_FREQ), step);
      end
      if (longint'(tl_ppb) == target) pinned++;
    end
    // hold the clamp and project at it
    for (int k = 0; k < 8; k++) begin
      advance_core();
      op = opcode_t'(k % 4);
      issue_request(op, core_now, pick_operand(op), '0);
    end
  endtask

  // Result side: random stalls, check each result against the oldest prediction
  always @(posedge clk) begin : result_check
    int                gap;
    logic [TIME_W-1:0] want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold <= 0;
    end else begin
      gap = rsp_hold;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_times.size() == 0) begin
          note_error($sformatf("unexpected result_time %h", rsp_ch.result_time));
        end else begin
          want = expected_times.pop_front();
          if (rsp_ch.result_time !== want)
            note_error($sformatf("result_time mismatch: expected %h actual %h",
                                 want, rsp_ch.result_time));
        end
        result_count++;
        if (result_count % 64 == 0) rsp_gaps_on = ($urandom_range(0, 3) != 0);
        gap = draw_gap(rsp_gaps_on);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold <= gap - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        rsp_hold <= 0;
      end
    end
  end

  initial begin
    tl_offset = '0;
    tl_anchor = '0;
    tl_ppb = '0;
    core_now = '0;
    err_count = 0;
    req_count = 0;
    result_count = 0;
    req_gaps_on = 1'b1;
    rsp_gaps_on = 1'b1;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= '0;
    req_ch.core_time <= '0;
    req_ch.operand_time <= '0;
    req_ch.freq_adjust_ppb <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic();
    test_freq_clamp();

    // drain, then give a stray result time to show up
    req_ch.valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_if.sv
hw/rtl/dtc_serial_mul.sv
hw/rtl/dtc_serial_div.sv
hw/rtl/disciplined_timeline_clock.sv
verif/tb.sv
